>>> rtl/core/rm_pkg.sv
// ----------------------------------------------------------------------------
// rm_pkg: shared definitions for the running median block
// Store depth, derived widths and the control bundle that the top level
// drives into the row of insertion cells.
// ----------------------------------------------------------------------------
package rm_pkg;

  // store depth and derived widths
  localparam int CAPACITY = 256;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

  // read tree: cells per registered group
  localparam int GRP      = 16;
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

  // field widths
  localparam int SMP_W    = 16;
  localparam int MED_W    = 17;
  localparam int OCNT_W   = 9;

  // control bundle, top level to every cell
  typedef struct packed {
    logic             ins_en;   // insert sample this cycle
    logic [SMP_W-1:0] sample;   // sample being inserted
    logic [CNT_W-1:0] count;    // entries held before the insert
    logic [IDX_W-1:0] sel_hi;   // upper middle entry
    logic [IDX_W-1:0] sel_lo;   // lower middle entry
  } rm_ctl_t;

endpackage

>>> rtl/core/rm_cell.sv
// ----------------------------------------------------------------------------
// rm_cell: one entry of the sorted store
// Compares the incoming sample with its entry and either keeps it, takes the
// sample, or takes its left neighbour's entry, so the row stays ascending.
// Also offers its entry to the read tree when it is a middle entry.
// ----------------------------------------------------------------------------
module rm_cell (
  input  logic                  clk,
  input  rm_pkg::rm_ctl_t       ctl,
  input  logic [rm_pkg::IDX_W-1:0] idx,
  input  logic [rm_pkg::SMP_W-1:0] left_val,
  input  logic                  left_gt,
  output logic [rm_pkg::SMP_W-1:0] val,
  output logic                  gt,
  output logic [rm_pkg::SMP_W-1:0] rd_hi,
  output logic [rm_pkg::SMP_W-1:0] rd_lo
);
  import rm_pkg::*;

  logic [SMP_W-1:0] val_r;
  logic [SMP_W-1:0] val_nxt;
  logic             held;

  // an entry beyond the count acts as plus infinity
  assign held = CNT_W'(idx) < ctl.count;
  assign gt   = !held || ($signed(val_r) > $signed(ctl.sample));

  // shift right where the left entry is larger, drop the sample at the edge
  always_comb begin
    priority if (!ctl.ins_en) begin
      val_nxt = val_r;
    end else if (left_gt) begin
      val_nxt = left_val;
    end else if (gt) begin
      val_nxt = ctl.sample;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val   = val_r;
  assign rd_hi = (idx == ctl.sel_hi) ? val_r : '0;
  assign rd_lo = (idx == ctl.sel_lo) ? val_r : '0;

endmodule

>>> rtl/core/rm_pick.sv
// ----------------------------------------------------------------------------
// rm_pick: read tree for the two middle entries
// Each cell offers zero unless selected; groups are OR-ed into registers,
// the group registers are OR-ed into the two middle values.
// ----------------------------------------------------------------------------
module rm_pick (
  input  logic                     clk,
  input  logic                     gather,
  input  logic [rm_pkg::SMP_W-1:0] hi_in [rm_pkg::CAPACITY],
  input  logic [rm_pkg::SMP_W-1:0] lo_in [rm_pkg::CAPACITY],
  output logic [rm_pkg::SMP_W-1:0] hi_val,
  output logic [rm_pkg::SMP_W-1:0] lo_val
);
  import rm_pkg::*;

  logic [SMP_W-1:0] grp_hi_r [NGRP];
  logic [SMP_W-1:0] grp_lo_r [NGRP];

  // first level: registered OR per group
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    logic [SMP_W-1:0] or_hi;
    logic [SMP_W-1:0] or_lo;

    always_comb begin
      or_hi = '0;
      or_lo = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) begin
          or_hi = or_hi | hi_in[g * GRP + k];
          or_lo = or_lo | lo_in[g * GRP + k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (gather) begin
        grp_hi_r[g] <= or_hi;
        grp_lo_r[g] <= or_lo;
      end
    end
  end

  // second level: OR over the group registers
  always_comb begin
    hi_val = '0;
    lo_val = '0;
    for (int g = 0; g < NGRP; g++) begin
      hi_val = hi_val | grp_hi_r[g];
      lo_val = lo_val | grp_lo_r[g];
    end
  end

endmodule

>>> rtl/core/running_median.sv
// ----------------------------------------------------------------------------
// running_median: running median of a stream of signed samples
// Sorted store built as a row of insertion cells; reports twice the median,
// the held count and an overflow flag for every sample.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                              tuser     tlast
//  in_      in   [15:0] sample                      -         last_in_stream
//  out_     out  [16:0] median_doubled,             overflow  -
//                [25:17] sample_count, [31:26] zero
//
//  A beat passes through accept, insert in the cell row, gather of the
//  middle entries in the first tree level, and add into the output register.
//  The cell row does the insert; the two-level read tree takes gather and add.
//  A result waits in the output register; the next beat is accepted meanwhile
//  and stalls at the add step until the output is free.
//  Synchronous active-low reset empties the store; entry contents stay as is.
// ----------------------------------------------------------------------------
module running_median (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic        in_tlast,   // last_in_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [16:0] median_doubled, [25:17] sample_count
  output logic        out_tuser   // overflow
);
  import rm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_GATH = 4'b0100,
    S_SUM  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SMP_W-1:0] smp_r;
  logic             last_r;
  logic             pend_ovf_r;
  logic [CNT_W-1:0] pend_cnt_r;
  logic [IDX_W-1:0] sel_hi_r, sel_lo_r;
  logic             out_valid_r;
  logic [31:0]      out_data_r;
  logic             out_user_r;

  logic             in_beat, full, out_free, do_sum;
  logic [CNT_W-1:0] c_after;
  logic [IDX_W-1:0] mid_idx;
  rm_ctl_t          ctl;

  logic [SMP_W-1:0] cell_val [CAPACITY];
  logic             cell_gt  [CAPACITY];
  logic [SMP_W-1:0] rd_hi    [CAPACITY];
  logic [SMP_W-1:0] rd_lo    [CAPACITY];
  logic [SMP_W-1:0] hi_val, lo_val;
  logic [MED_W-1:0] med2;
  logic [CNT_W+OCNT_W-1:0] cnt_ext;

  assign in_tready = state_r == S_IDLE;
  assign in_beat   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign do_sum    = (state_r == S_SUM) && out_free;

  // count after the insert and the two middle indices
  assign full    = count_r == CNT_W'(CAPACITY);
  assign c_after = full ? count_r : count_r + CNT_W'(1);
  assign mid_idx = IDX_W'(c_after >> 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_beat) state_nxt = S_INS;
      S_INS:  state_nxt = S_GATH;
      S_GATH: state_nxt = S_SUM;
      S_SUM:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // held count: bump on insert, clear after the last beat of a stream
  assign count_nxt = (state_r == S_INS) ? (last_r ? '0 : c_after) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (do_sum) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // beat capture and middle selection
  always_ff @(posedge clk) begin
    if (in_beat) begin
      smp_r  <= in_tdata;
      last_r <= in_tlast;
    end
    if (state_r == S_INS) begin
      pend_cnt_r <= c_after;
      pend_ovf_r <= full;
      sel_hi_r   <= mid_idx;
      sel_lo_r   <= c_after[0] ? mid_idx : mid_idx - IDX_W'(1);
    end
  end

  assign ctl.ins_en = (state_r == S_INS) && !full;
  assign ctl.sample = smp_r;
  assign ctl.count  = count_r;
  assign ctl.sel_hi = sel_hi_r;
  assign ctl.sel_lo = sel_lo_r;

  // row of insertion cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [SMP_W-1:0] lv;
    logic             lg;
    if (i == 0) begin : g_first
      assign lv = '0;
      assign lg = 1'b0;
    end else begin : g_rest
      assign lv = cell_val[i-1];
      assign lg = cell_gt[i-1];
    end
    rm_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .idx      (IDX_W'(i)),
      .left_val (lv),
      .left_gt  (lg),
      .val      (cell_val[i]),
      .gt       (cell_gt[i]),
      .rd_hi    (rd_hi[i]),
      .rd_lo    (rd_lo[i])
    );
  end

  rm_pick u_pick (
    .clk    (clk),
    .gather (state_r == S_GATH),
    .hi_in  (rd_hi),
    .lo_in  (rd_lo),
    .hi_val (hi_val),
    .lo_val (lo_val)
  );

  // twice the median; count masked to the field width
  assign med2    = MED_W'($signed(hi_val)) + MED_W'($signed(lo_val));
  assign cnt_ext = {{OCNT_W{1'b0}}, pend_cnt_r};

  always_ff @(posedge clk) begin
    if (do_sum) begin
      out_data_r <= {6'b0, cnt_ext[OCNT_W-1:0], med2};
      out_user_r <= pend_ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> rtl/core/rm_checker.sv
// ----------------------------------------------------------------------------
// rm_checker: port-level checks for running_median
// Watches both channels and flags slips in sequencing and result coding.
// ----------------------------------------------------------------------------
module rm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);
  import rm_pkg::*;

  localparam logic [OCNT_W-1:0] CAP_MASKED = OCNT_W'(CAPACITY % 512);

  logic out_beat;
  assign out_beat = out_tvalid && out_tready;

  // a pending result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // busy for the cycle after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("beat accepted during insert");

  // a rejected sample reports a full store
  a_ovf_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && out_tuser |-> out_tdata[25:17] == CAP_MASKED)
    else $error("overflow with store not full");

  // odd count gives an even doubled median
  a_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && out_tdata[17] |-> !out_tdata[0])
    else $error("odd count with odd doubled median");

endmodule

bind running_median rm_checker u_chk (.*);
